// File: hdl/vbb_pkg.sv
package vbb_pkg;

    // vertex coordinate width, signed Q8.8 at the default of 16
    localparam int COORD_BITS = 16;

    localparam int Q_BITS     = 24;
    localparam int COEF_BITS  = 16;
    localparam int FRAC_SHIFT = 12;
    localparam int ROW_BITS   = 64;
    localparam int AXES       = 3;
    localparam int CFG_INDEX_BITS = 2;

    localparam int PROD_BITS  = COEF_BITS + COORD_BITS;
    localparam int ACC_BITS   =
        ((PROD_BITS > Q_BITS + FRAC_SHIFT) ? PROD_BITS : Q_BITS + FRAC_SHIFT) + 2;
    localparam int QUOT_BITS  = ACC_BITS - FRAC_SHIFT;

    localparam logic signed [Q_BITS-1:0] Q_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
    localparam logic signed [Q_BITS-1:0] Q_MIN = {1'b1, {(Q_BITS-1){1'b0}}};

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_X = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_Y = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_Z = 2'd2;

    // identity transform
    localparam logic [ROW_BITS-1:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
    localparam logic [ROW_BITS-1:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
    localparam logic [ROW_BITS-1:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic signed [COORD_BITS-1:0] vertex_z;
        logic                         last_vertex;
    } vertex_t;

    typedef struct packed {
        logic signed [Q_BITS-1:0] center_x;
        logic signed [Q_BITS-1:0] center_y;
        logic signed [Q_BITS-1:0] center_z;
        logic        [Q_BITS-1:0] extent_x;
        logic        [Q_BITS-1:0] extent_y;
        logic        [Q_BITS-1:0] extent_z;
    } box_t;

endpackage

// File: hdl/vertex_bounding_box.sv
// channel   | direction | handshake                    | payload
// ----------+-----------+------------------------------+---------------------------------
// vertex    | in        | vertex_valid / vertex_ready  | vertex_t: x, y, z, last_vertex
// box       | out       | box_valid / box_ready        | box_t: centre and extent per axis
// cfg       | in        | cfg_write (no wait)          | cfg_index, cfg_data (matrix rows)
//
// one vertex request per cycle unless stalled; a box is registered once its last vertex has passed the stages below
// stages: input register, multiplier register, transform register, box register
// the pipeline stalls only when a last vertex reaches the extremes stage while the
// box register still holds an untaken box
// rst_n is asynchronous active low: identity matrix, extremes re-armed, pipeline empty
module vertex_bounding_box
    import vbb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // matrix rows
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ROW_BITS-1:0]       cfg_data,
    // vertex stream
    input  logic                      vertex_valid,
    output logic                      vertex_ready,
    input  vertex_t                   vertex,
    // bounding box results
    output logic                      box_valid,
    input  logic                      box_ready,
    output box_t                      box
);

    // matrix row registers, one per output axis
    logic [ROW_BITS-1:0] row_reg [AXES];

    // pipeline registers
    logic                         s1_valid_reg;
    vertex_t                      s1_vertex_reg;
    logic                         s2_valid_reg;
    logic                         s2_last_reg;
    logic signed [PROD_BITS-1:0]  s2_prod_reg [AXES][AXES];
    logic                         s3_valid_reg;
    logic                         s3_last_reg;
    logic signed [Q_BITS-1:0]     s3_coord_reg [AXES];

    // running extremes
    logic signed [Q_BITS-1:0]     low_reg  [AXES];
    logic signed [Q_BITS-1:0]     high_reg [AXES];

    // result register
    logic                         box_valid_reg;
    box_t                         box_reg;

    logic                         advance;
    logic                         box_load;
    logic signed [COORD_BITS-1:0] s1_coord [AXES];
    logic signed [PROD_BITS-1:0]  s2_prod_next [AXES][AXES];
    logic signed [Q_BITS-1:0]     s3_coord_next [AXES];
    logic signed [Q_BITS-1:0]     low_next  [AXES];
    logic signed [Q_BITS-1:0]     high_next [AXES];
    logic signed [Q_BITS-1:0]     center [AXES];
    logic        [Q_BITS-1:0]     extent [AXES];
    box_t                         box_next;

    // the only hold-up: a finished box waiting while the next one is ready to land
    assign advance      = !(s3_valid_reg && s3_last_reg && box_valid_reg && !box_ready);
    assign vertex_ready = advance;
    assign box_load     = advance && s3_valid_reg && s3_last_reg;

    // configuration writes, unused index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_X_RESET;
            row_reg[1] <= ROW_Y_RESET;
            row_reg[2] <= ROW_Z_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ROW_X: row_reg[0] <= cfg_data;
                CFG_ROW_Y: row_reg[1] <= cfg_data;
                CFG_ROW_Z: row_reg[2] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // stage 1: input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= vertex_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && vertex_valid)
        begin
            s1_vertex_reg <= vertex;
        end
    end

    assign s1_coord[0] = s1_vertex_reg.vertex_x;
    assign s1_coord[1] = s1_vertex_reg.vertex_y;
    assign s1_coord[2] = s1_vertex_reg.vertex_z;

    // stage 2: nine coefficient products, one multiplier each
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                s2_prod_next[a][k] =
                    PROD_BITS'($signed(row_reg[a][COEF_BITS*k +: COEF_BITS]))
                    * PROD_BITS'(s1_coord[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_last_reg  <= s1_vertex_reg.last_vertex;
            s2_prod_reg  <= s2_prod_next;
        end
    end

    // stage 3: sum with translation, floor to Q16.8, saturate
    always_comb
    begin
        logic signed [ACC_BITS-1:0]  acc;
        logic signed [QUOT_BITS-1:0] quot;
        for (int a = 0; a < AXES; a++)
        begin
            acc = ACC_BITS'(s2_prod_reg[a][0]) + ACC_BITS'(s2_prod_reg[a][1])
                + ACC_BITS'(s2_prod_reg[a][2])
                + ACC_BITS'($signed({row_reg[a][ROW_BITS-1 -: COEF_BITS],
                                     {FRAC_SHIFT{1'b0}}}));
            // arithmetic shift floors toward minus infinity
            quot = $signed(acc[ACC_BITS-1:FRAC_SHIFT]);
            if (quot > QUOT_BITS'(Q_MAX))
                s3_coord_next[a] = Q_MAX;
            else if (quot < QUOT_BITS'(Q_MIN))
                s3_coord_next[a] = Q_MIN;
            else
                s3_coord_next[a] = quot[Q_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            s3_last_reg  <= s2_last_reg;
            s3_coord_reg <= s3_coord_next;
        end
    end

    // stage 4: fold into extremes; on the last vertex form centre and extent
    always_comb
    begin
        logic signed [Q_BITS:0] pair_sum;
        for (int a = 0; a < AXES; a++)
        begin
            low_next[a]  = (s3_coord_reg[a] < low_reg[a])  ? s3_coord_reg[a] : low_reg[a];
            high_next[a] = (s3_coord_reg[a] > high_reg[a]) ? s3_coord_reg[a] : high_reg[a];
            pair_sum     = (Q_BITS+1)'(low_next[a]) + (Q_BITS+1)'(high_next[a]);
            // dropping the low bit of a signed sum is a floor halving
            center[a]    = pair_sum[Q_BITS:1];
            extent[a]    = high_next[a] - low_next[a];
        end
    end

    always_comb
    begin
        box_next.center_x = center[0];
        box_next.center_y = center[1];
        box_next.center_z = center[2];
        box_next.extent_x = extent[0];
        box_next.extent_y = extent[1];
        box_next.extent_z = extent[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                low_reg[a]  <= Q_MAX;
                high_reg[a] <= Q_MIN;
            end
        end
        else if (advance && s3_valid_reg)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                // re-arm after a last vertex
                low_reg[a]  <= s3_last_reg ? Q_MAX : low_next[a];
                high_reg[a] <= s3_last_reg ? Q_MIN : high_next[a];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_valid_reg <= 1'b0;
        end
        else if (box_load)
        begin
            box_valid_reg <= 1'b1;
        end
        else if (box_ready)
        begin
            box_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (box_load)
        begin
            box_reg <= box_next;
        end
    end

    assign box_valid = box_valid_reg;
    assign box       = box_reg;

endmodule

// File: hdl/vbb_checker.sv
module vbb_checker
    import vbb_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      vertex_ready,
    input logic                      box_valid,
    input logic                      box_ready,
    input box_t                      box
);

    // min and max recovered from centre and extent must both be in range
    function automatic logic box_fits(logic signed [Q_BITS-1:0] c, logic [Q_BITS-1:0] e);
        logic signed [Q_BITS+1:0] lo;
        logic signed [Q_BITS+1:0] hi;
        begin
            lo = (Q_BITS+2)'(c) - $signed({3'b000, e[Q_BITS-1:1]});
            hi = (Q_BITS+2)'(c) + $signed({2'b00, e}) - $signed({3'b000, e[Q_BITS-1:1]});
            return (lo >= (Q_BITS+2)'(Q_MIN)) && (hi <= (Q_BITS+2)'(Q_MAX));
        end
    endfunction

    logic fits_all;

    assign fits_all = box_fits(box.center_x, box.extent_x)
                   && box_fits(box.center_y, box.extent_y)
                   && box_fits(box.center_z, box.extent_z);

    // a pending box is held until taken
    a_box_held: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !box_ready |=> box_valid)
        else $error("box request dropped before it was taken");

    a_box_stable: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !box_ready |=> $stable(box))
        else $error("box payload changed while stalled");

    // an empty result register never blocks the vertex stream
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !box_valid |-> vertex_ready)
        else $error("vertex stream stalled with no box pending");

    // centre and extent describe a box inside the Q16.8 range
    a_box_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid |-> fits_all)
        else $error("box centre and extent imply an out-of-range extreme");

endmodule

bind vertex_bounding_box vbb_checker u_vbb_checker (.*);
